// File: rtl/core/nps_pkg.sv
// Package of the nearest path edge search: sizes, opcodes and the structs
// that pass between the top level, the normalizer and the edge cells.
// Depends on nothing.
`timescale 1ns / 1ps

package nps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_EDGES  = MAX_POINTS - 1;

  localparam int COORD_W = 32;
  localparam int DIR_W   = FRAC_BITS + 3;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int IDX_W   = 6;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + DIR_W;
  localparam int DSUM_W  = PROD_W + 2;
  localparam int DOT_W   = DSUM_W - FRAC_BITS;
  localparam int PROJ_W  = DOT_W + DIR_W;
  localparam int OFS_W   = PROJ_W - FRAC_BITS + 1;
  localparam int DIST_W  = 2 * COORD_W;
  localparam int CELL_LAT = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
  } dir_t;

  typedef struct packed {
    point_t start;
    dir_t   dir;
  } seg_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_len;
  } token_t;

endpackage

// File: rtl/core/nearest_path_edge_search.sv
// Top level of the nearest path edge search: control, path registers,
// the normalizer and the row of edge cells.
// Depends on nps_pkg, nps_norm and nps_cell.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Handshake
// in        input      in_opcode, in_coord_x/y/z               in_valid / in_stall
// out       output     out_edge_found, out_edge_index          out_valid / out_stall
//
// A clear, an ignored word, the first point or an append to a full path leaves the input unstalled.
// Any other append sums the squares, takes the square root bit by bit, runs the
// divider for each of three components and writes the edge; a zero-length
// edge skips the divider.
// A query waits while the cell pipeline settles, then the search word walks down the
// row, and the result is presented once the result side is free.
// Reset is synchronous and active low; the edge cells hold no reset payload.
// A finished result waits in the output register, and a new word is taken while
// it waits; a second query then holds before its result until the first leaves.

module nearest_path_edge_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic signed [nps_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [nps_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [nps_pkg::COORD_W-1:0] in_coord_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_edge_found,
  output logic [nps_pkg::IDX_W-1:0]         out_edge_index
);

  localparam int NE     = nps_pkg::MAX_EDGES;
  localparam int CNT_W  = nps_pkg::CNT_W;
  localparam int WAIT_W = $clog2(nps_pkg::CELL_LAT);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_NORM = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } st_t;

  st_t st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  nps_pkg::point_t prev_r, prev_nxt;
  nps_pkg::point_t pt_r;
  nps_pkg::point_t in_pt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  nps_pkg::token_t inj_r, inj_nxt;
  nps_pkg::token_t tok_chain [NE+1];
  logic res_found_r;
  logic [nps_pkg::IDX_W-1:0] res_idx_r;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r;
  logic [nps_pkg::IDX_W-1:0] out_idx_r;

  logic in_acc;
  nps_pkg::op_t op;
  logic norm_start;
  logic norm_done;
  nps_pkg::dir_t norm_dir;
  logic wr_go;
  logic [CNT_W-1:0] wr_idx;
  nps_pkg::seg_t wr_seg;
  logic load_out;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign op       = nps_pkg::op_t'(in_opcode);
  assign in_pt.x  = in_coord_x;
  assign in_pt.y  = in_coord_y;
  assign in_pt.z  = in_coord_z;

  // The first point only becomes the previous point; later points start a
  // normalization unless the path is full.
  assign norm_start = in_acc && (op == nps_pkg::OP_APPEND) && (cnt_r != '0)
                      && (cnt_r != CNT_W'(nps_pkg::MAX_POINTS));

  nps_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .pt    (in_pt),
    .prev  (prev_r),
    .done  (norm_done),
    .dir   (norm_dir)
  );

  assign wr_go        = (st_r == ST_NORM) && norm_done;
  assign wr_idx       = cnt_r - CNT_W'(1);
  assign wr_seg.start = prev_r;
  assign wr_seg.dir   = norm_dir;

  // Cell k holds edge k; the search word enters at cell 0.
  assign tok_chain[0] = inj_r;

  for (genvar k = 0; k < NE; k++) begin : g_cell
    nps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_go && (wr_idx == CNT_W'(k))),
      .wr_seg   (wr_seg),
      .q_pt     (pt_r),
      .active   ((CNT_W'(k) + CNT_W'(1)) < cnt_r),
      .cell_idx (nps_pkg::IDX_W'(k)),
      .tok_in   (tok_chain[k]),
      .tok_out  (tok_chain[k+1])
    );
  end

  assign load_out = (st_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    wait_nxt = wait_r;
    inj_nxt  = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            nps_pkg::OP_APPEND: begin
              if (norm_start) begin
                st_nxt = ST_NORM;
              end else if (cnt_r == '0) begin
                prev_nxt = in_pt;
                cnt_nxt  = CNT_W'(1);
              end
            end
            nps_pkg::OP_CLEAR: begin
              cnt_nxt  = '0;
              prev_nxt = '0;
            end
            nps_pkg::OP_QUERY: begin
              wait_nxt = '0;
              st_nxt   = ST_WAIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          prev_nxt = pt_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
          st_nxt   = ST_IDLE;
        end
      end
      ST_WAIT: begin
        wait_nxt = wait_r + WAIT_W'(1);
        if (wait_r == WAIT_W'(nps_pkg::CELL_LAT - 1)) begin
          inj_nxt.valid = 1'b1;
          st_nxt        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_chain[NE].valid) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      prev_r      <= '0;
      wait_r      <= '0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      wait_r      <= wait_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_r <= in_pt;
    end
    if ((st_r == ST_SCAN) && tok_chain[NE].valid) begin
      res_found_r <= tok_chain[NE].found;
      res_idx_r   <= tok_chain[NE].idx;
    end
    if (load_out) begin
      out_found_r <= res_found_r;
      out_idx_r   <= res_idx_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_found = out_found_r;
  assign out_edge_index = out_idx_r;

  // The path never holds more points than it has room for.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(nps_pkg::MAX_POINTS))
    else $error("point count beyond capacity");

  // The search word leaves the last cell only while a query scans.
  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[NE].valid |-> (st_r == ST_SCAN))
    else $error("search word outside a scan");

  // The normalizer finishes only while an append waits for it.
  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (st_r == ST_NORM))
    else $error("normalizer finished outside an append");

  // A scan started from the wait phase begins with an injected word.
  a_inject: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_WAIT) && (st_nxt == ST_SCAN)) |=> inj_r.valid)
    else $error("scan started without a search word");

endmodule

// File: rtl/core/nps_norm.sv
// Edge direction normalizer: squares, bit-serial integer square root and
// a restoring divider shared by the three components.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  nps_pkg::point_t pt,
  input  nps_pkg::point_t prev,
  output logic            done,
  output nps_pkg::dir_t   dir
);

  localparam int NUM_W  = nps_pkg::COORD_W + nps_pkg::FRAC_BITS + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int REM_W  = nps_pkg::COORD_W + 2;
  localparam int DW     = nps_pkg::DIR_W;
  localparam int CW     = nps_pkg::COORD_W;

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_SQ   = 5'b00010,
    N_ROOT = 5'b00100,
    N_DIV  = 5'b01000,
    N_DONE = 5'b10000
  } nst_t;

  nst_t st_r, st_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic signed [CW-1:0] ds_r [3];
  logic signed [CW-1:0] ds_nxt [3];
  logic [2*CW-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0] root_r, root_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0] drem_r, drem_nxt;
  logic signed [DW-1:0] dir_r [3];
  logic signed [DW-1:0] dir_nxt [3];

  logic signed [nps_pkg::DIFF_W-1:0] d [3];
  logic [2:0] big;
  logic shift1;
  logic signed [CW-1:0] ds_sel;
  logic [CW-1:0] mag;
  logic [2*CW-1:0] sq;
  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic [CW:0] rt;
  logic ge;

  // True when the magnitude of a difference reaches 2^31.
  function automatic logic is_big(input logic [nps_pkg::DIFF_W-1:0] v);
    logic neg_big;
    neg_big = v[CW] && !(v[CW-1] && (v[CW-2:0] != '0));
    return (!v[CW] && v[CW-1]) || neg_big;
  endfunction

  assign d[0] = {pt.x[CW-1], pt.x} - {prev.x[CW-1], prev.x};
  assign d[1] = {pt.y[CW-1], pt.y} - {prev.y[CW-1], prev.y};
  assign d[2] = {pt.z[CW-1], pt.z} - {prev.z[CW-1], prev.z};
  assign big[0] = is_big(d[0]);
  assign big[1] = is_big(d[1]);
  assign big[2] = is_big(d[2]);
  assign shift1 = |big;

  assign ds_sel = ds_r[comp_r];
  assign mag    = ds_sel[CW-1] ? CW'(-ds_sel) : ds_sel;
  assign sq     = ds_sel * ds_sel;
  assign rem_t  = {rem_r, rad_r[2*CW-1:2*CW-2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign rt     = {drem_r, num_r[NUM_W-1]};
  assign ge     = rt >= {1'b0, root_r};

  always_comb begin
    logic [NUM_W-1:0] qf;
    logic [NUM_W-1:0] lim;
    st_nxt   = st_r;
    comp_nxt = comp_r;
    step_nxt = step_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    drem_nxt = drem_r;
    lim      = NUM_W'(1) << (DW - 1);
    qf       = '0;
    for (int i = 0; i < 3; i++) begin
      ds_nxt[i]  = ds_r[i];
      dir_nxt[i] = dir_r[i];
    end
    case (st_r)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            ds_nxt[i] = shift1 ? d[i][CW:1] : d[i][CW-1:0];
          end
          rad_nxt  = '0;
          comp_nxt = '0;
          st_nxt   = N_SQ;
        end
      end
      N_SQ: begin
        rad_nxt  = rad_r + sq;
        comp_nxt = comp_r + 2'd1;
        if (comp_r == 2'd2) begin
          comp_nxt = '0;
          step_nxt = '0;
          rem_nxt  = '0;
          root_nxt = '0;
          st_nxt   = N_ROOT;
        end
      end
      N_ROOT: begin
        if (rem_t >= trial) begin
          rem_nxt  = REM_W'(rem_t - trial);
          root_nxt = {root_r[CW-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(rem_t);
          root_nxt = {root_r[CW-2:0], 1'b0};
        end
        rad_nxt  = rad_r << 2;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CW - 1)) begin
          step_nxt = '0;
          comp_nxt = '0;
          st_nxt   = N_DIV;
        end
      end
      N_DIV: begin
        if (step_r == '0) begin
          if (root_r == '0) begin
            for (int i = 0; i < 3; i++) begin
              dir_nxt[i] = '0;
            end
            st_nxt = N_DONE;
          end else begin
            num_nxt  = NUM_W'({mag, {nps_pkg::FRAC_BITS{1'b0}}}) + NUM_W'(root_r >> 1);
            quo_nxt  = '0;
            drem_nxt = '0;
            step_nxt = STEP_W'(1);
          end
        end else begin
          num_nxt  = num_r << 1;
          drem_nxt = ge ? CW'(rt - {1'b0, root_r}) : rt[CW-1:0];
          quo_nxt  = {quo_r[NUM_W-2:0], ge};
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(NUM_W)) begin
            qf = quo_nxt;
            if (ds_sel[CW-1]) begin
              dir_nxt[comp_r] = (qf >= lim) ? DW'(NUM_W'(0) - lim) : DW'(NUM_W'(0) - qf);
            end else begin
              dir_nxt[comp_r] = (qf >= lim) ? DW'(lim - NUM_W'(1)) : DW'(qf);
            end
            step_nxt = '0;
            comp_nxt = comp_r + 2'd1;
            if (comp_r == 2'd2) begin
              st_nxt = N_DONE;
            end
          end
        end
      end
      N_DONE: begin
        st_nxt = N_IDLE;
      end
      default: begin
        st_nxt = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    comp_r <= comp_nxt;
    step_r <= step_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    drem_r <= drem_nxt;
    for (int i = 0; i < 3; i++) begin
      ds_r[i]  <= ds_nxt[i];
      dir_r[i] <= dir_nxt[i];
    end
  end

  assign done  = (st_r == N_DONE);
  assign dir.x = dir_r[0];
  assign dir.y = dir_r[1];
  assign dir.z = dir_r[2];

endmodule

// File: rtl/core/nps_cell.sv
// One edge cell: holds one edge, computes its squared x/z offset to the
// query point in a short pipeline and updates the passing search word.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  nps_pkg::seg_t               wr_seg,
  input  nps_pkg::point_t             q_pt,
  input  logic                        active,
  input  logic [nps_pkg::IDX_W-1:0]   cell_idx,
  input  nps_pkg::token_t             tok_in,
  output nps_pkg::token_t             tok_out
);

  localparam int CW = nps_pkg::COORD_W;
  localparam int FB = nps_pkg::FRAC_BITS;

  nps_pkg::seg_t seg_r;
  nps_pkg::token_t tok_r, tok_nxt;

  logic signed [nps_pkg::DIR_W-1:0] dx, dy, dz;
  logic signed [nps_pkg::DIFF_W-1:0] vx_r, vy_r, vz_r;
  logic signed [nps_pkg::PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [nps_pkg::DSUM_W-1:0] dsum_rnd;
  logic signed [nps_pkg::DOT_W-1:0] dot_r;
  logic signed [nps_pkg::PROJ_W-1:0] qx_r, qz_r;
  logic signed [nps_pkg::PROJ_W-1:0] qx_rnd, qz_rnd;
  logic signed [nps_pkg::OFS_W-1:0] ofx, ofz;
  logic signed [CW-1:0] ox_r, oz_r;
  logic [nps_pkg::DIST_W-1:0] sqx_r, sqz_r, dist_r;

  function automatic logic signed [CW-1:0] sat32(input logic signed [nps_pkg::OFS_W-1:0] v);
    logic signed [nps_pkg::OFS_W-1:0] hi;
    logic signed [nps_pkg::OFS_W-1:0] lo;
    hi = nps_pkg::OFS_W'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - nps_pkg::OFS_W'(1);
    if (v > hi) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return v[CW-1:0];
  endfunction

  assign dx = seg_r.dir.x;
  assign dy = seg_r.dir.y;
  assign dz = seg_r.dir.z;

  assign dsum_rnd = nps_pkg::DSUM_W'(px_r) + nps_pkg::DSUM_W'(py_r) + nps_pkg::DSUM_W'(pz_r)
                    + (nps_pkg::DSUM_W'(1) << (FB - 1));
  assign qx_rnd = qx_r + (nps_pkg::PROJ_W'(1) << (FB - 1));
  assign qz_rnd = qz_r + (nps_pkg::PROJ_W'(1) << (FB - 1));
  assign ofx = nps_pkg::OFS_W'(signed'(qx_rnd[nps_pkg::PROJ_W-1:FB])) - nps_pkg::OFS_W'(vx_r);
  assign ofz = nps_pkg::OFS_W'(signed'(qz_rnd[nps_pkg::PROJ_W-1:FB])) - nps_pkg::OFS_W'(vz_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_r <= wr_seg;
    end
  end

  always_ff @(posedge clk) begin
    vx_r   <= {q_pt.x[CW-1], q_pt.x} - {seg_r.start.x[CW-1], seg_r.start.x};
    vy_r   <= {q_pt.y[CW-1], q_pt.y} - {seg_r.start.y[CW-1], seg_r.start.y};
    vz_r   <= {q_pt.z[CW-1], q_pt.z} - {seg_r.start.z[CW-1], seg_r.start.z};
    px_r   <= vx_r * dx;
    py_r   <= vy_r * dy;
    pz_r   <= vz_r * dz;
    dot_r  <= dsum_rnd[nps_pkg::DSUM_W-1:FB];
    qx_r   <= dot_r * dx;
    qz_r   <= dot_r * dz;
    ox_r   <= sat32(ofx);
    oz_r   <= sat32(ofz);
    sqx_r  <= ox_r * ox_r;
    sqz_r  <= oz_r * oz_r;
    dist_r <= sqx_r + sqz_r;
  end

  // Strict less-than keeps the earlier edge on a tie.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && active && (!tok_in.found || dist_r < tok_in.sq_len)) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.idx    = cell_idx;
      tok_nxt.sq_len = dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: test/nearest_path_edge_search_test.sv
// Testbench of nearest_path_edge_search: a short table of directed words, then random path
// sequences, checked against a fixed-point nearest-edge predictor or hand-typed answers.
// Depends on nps_pkg and the nearest_path_edge_search RTL.
`timescale 1ns / 1ps

module nearest_path_edge_search_test;

  localparam int MAX_POINTS = nps_pkg::MAX_POINTS;
  localparam int MAX_EDGES  = nps_pkg::MAX_EDGES;
  localparam int FRAC_BITS  = nps_pkg::FRAC_BITS;
  localparam int COORD_W    = nps_pkg::COORD_W;
  localparam int DIR_W      = nps_pkg::DIR_W;
  localparam int IDX_W      = nps_pkg::IDX_W;

  typedef nps_pkg::op_t op_t;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_WORDS = 1500;
  localparam int N_DIRECTED = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = nps_pkg::OP_NONE;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic signed [COORD_W-1:0] in_coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_edge_found;
  logic [IDX_W-1:0] out_edge_index;

  // The clock runs with a 12 ns period.
  always #6 clk = ~clk;

  nearest_path_edge_search DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_edge_found(out_edge_found),
    .out_edge_index(out_edge_index)
  );

  // One expected query answer.
  typedef struct {
    bit found;
    logic [IDX_W-1:0] idx;
  } answer_t;

  // One row of the directed table; typed rows carry their answer by hand.
  typedef struct {
    op_t op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit typed;
    bit found;
    logic [IDX_W-1:0] idx;
  } row_t;

  answer_t pending_answers[$];
  int error_count = 0;
  int cycle_count = 0;

  // The predictor keeps its own copy of the path: point count, the last point and,
  // for each edge, its start point and its normalized direction.
  int path_points = 0;
  longint last_pt[3];
  longint seg_start[MAX_EDGES][3];
  longint seg_dir[MAX_EDGES][3];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Direction component: d / len in FRAC_BITS fraction bits, rounded half away from zero,
  // saturated to the direction width.
  function automatic longint unit_component(longint d, longint unsigned len);
    longint lim;
    longint unsigned n;
    longint q;
    lim = longint'(1) <<< (DIR_W - 1);
    n = longint'(d < 0 ? -d : d) << FRAC_BITS;
    q = longint'((n + len / 2) / len);
    if (d < 0) q = -q;
    if (q < -lim) q = -lim;
    if (q > lim - 1) q = lim - 1;
    return q;
  endfunction

  function automatic void path_append(longint p[3]);
    longint d[3];
    longint m;
    longint a;
    int s;
    int k;
    longint unsigned sum;
    longint unsigned len;
    if (path_points >= MAX_POINTS) return;
    if (path_points >= 1) begin
      k = path_points - 1;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = p[i] - last_pt[i];
        a = d[i] < 0 ? -d[i] : d[i];
        if (a > m) m = a;
      end
      // Wide differences are scaled down (floor) until every component fits 31 bits.
      s = 0;
      while ((m >>> s) >= (longint'(1) <<< 31)) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = d[i] >>> s;
        sum += longint'(d[i] * d[i]);
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        seg_start[k][i] = last_pt[i];
        seg_dir[k][i] = (len == 0) ? 0 : unit_component(d[i], len);
      end
    end
    for (int i = 0; i < 3; i++) last_pt[i] = p[i];
    path_points++;
  endfunction

  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint sat32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  // Squared x/z length of the perpendicular offset from the point to the edge's line.
  function automatic longint unsigned line_offset_sq(int k, longint p[3]);
    longint v[3];
    longint dot;
    longint ox;
    longint oz;
    for (int i = 0; i < 3; i++) v[i] = p[i] - seg_start[k][i];
    dot = round_frac(v[0] * seg_dir[k][0] + v[1] * seg_dir[k][1] + v[2] * seg_dir[k][2]);
    ox = sat32(round_frac(seg_dir[k][0] * dot) - v[0]);
    oz = sat32(round_frac(seg_dir[k][2] * dot) - v[2]);
    return longint'(ox * ox) + longint'(oz * oz);
  endfunction

  function automatic answer_t nearest_edge(longint p[3]);
    answer_t ans;
    int edges;
    longint unsigned best_d;
    longint unsigned d;
    ans.found = 1'b0;
    ans.idx = '0;
    edges = path_points >= 2 ? path_points - 1 : 0;
    if (edges == 0) return ans;
    ans.found = 1'b1;
    best_d = line_offset_sq(0, p);
    for (int k = 1; k < edges; k++) begin
      d = line_offset_sq(k, p);
      // Strictly smaller only, so the earlier edge keeps a tie.
      if (d < best_d) begin
        best_d = d;
        ans.idx = k[IDX_W-1:0];
      end
    end
    return ans;
  endfunction

  // Runs one accepted word through the predictor. A query queues its answer, or the
  // hand-typed one when the caller gives it.
  function automatic void predict_word(op_t op, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, bit typed, answer_t typed_ans);
    longint p[3];
    p[0] = longint'(signed'(x));
    p[1] = longint'(signed'(y));
    p[2] = longint'(signed'(z));
    case (op)
      nps_pkg::OP_APPEND: path_append(p);
      nps_pkg::OP_CLEAR: begin
        path_points = 0;
        for (int i = 0; i < 3; i++) last_pt[i] = 0;
      end
      nps_pkg::OP_QUERY: pending_answers = {pending_answers,
                                            typed ? typed_ans : nearest_edge(p)};
      default: ;
    endcase
  endfunction

  // Gap lengths: usually none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one word. It holds valid high across back-to-back words, so valid is only
  // lowered when a gap comes first.
  task automatic send_word(op_t op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit typed, answer_t typed_ans);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (in_stall);
    predict_word(op, x, y, z, typed, typed_ans);
  endtask

  // Coordinates: the full range, a small cluster near the origin so that the edges lie
  // close together, and the extremes.
  function automatic logic [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom;
    if (r < 8) return 32'(signed'($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
    case ($urandom_range(0, 3))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      default: return 32'h00000000;
    endcase
  endfunction

  task automatic send_random(op_t op);
    answer_t none;
    none.found = 1'b0;
    none.idx = '0;
    send_word(op, pick_coord(), pick_coord(), pick_coord(), 1'b0, none);
  endtask

  // The result side stalls in bursts: mostly short ones, a few long, and open stretches.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    end else begin
      stall_left--;
    end
  end

  // Every result taken is compared with the oldest answer still owed.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result found=%0b index=%0d with no query waiting", $time,
                 out_edge_found, out_edge_index);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_edge_found !== want.found) begin
          $display("%0t: edge_found expected %0b, got %0b", $time, want.found, out_edge_found);
          error_count++;
        end
        if (out_edge_index !== want.idx) begin
          $display("%0t: edge_index expected %0d, got %0d", $time, want.idx, out_edge_index);
          error_count++;
        end
      end
    end
  end

  // A stuck block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_path_edge_search_test failed");
      $finish;
    end
  end

  // Directed table. Typed rows are answers that can be read off at sight: no edges
  // yet, a single edge, and an exact tie between an edge and its reverse.
  row_t directed [N_DIRECTED] = '{
    '{nps_pkg::OP_QUERY,  32'h00000000, 32'h00000000, 32'h00000000, 1, 0, 0},  // empty
    '{nps_pkg::OP_APPEND, 32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0},
    '{nps_pkg::OP_QUERY,  32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0, 0},  // no edge
    '{nps_pkg::OP_NONE,   32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0},  // ignored
    '{nps_pkg::OP_APPEND, 32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0},  // zero edge
    '{nps_pkg::OP_QUERY,  32'h00010000, 32'h00000000, 32'hfffe0000, 1, 1, 0},  // one edge
    '{nps_pkg::OP_APPEND, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0},
    '{nps_pkg::OP_APPEND, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0},  // widest
    '{nps_pkg::OP_APPEND, 32'h00010000, 32'h00000000, 32'h00000000, 0, 0, 0},
    '{nps_pkg::OP_QUERY,  32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0},
    '{nps_pkg::OP_QUERY,  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0},
    '{nps_pkg::OP_QUERY,  32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0},
    '{nps_pkg::OP_CLEAR,  32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0},
    '{nps_pkg::OP_QUERY,  32'h00000000, 32'h00000000, 32'h00000000, 1, 0, 0},  // cleared
    '{nps_pkg::OP_APPEND, 32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0},
    '{nps_pkg::OP_APPEND, 32'h00040000, 32'h00000000, 32'h00000000, 0, 0, 0},
    '{nps_pkg::OP_APPEND, 32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0},
    '{nps_pkg::OP_QUERY,  32'h00000000, 32'h00000000, 32'h00010000, 1, 1, 0},  // tie
    '{nps_pkg::OP_QUERY,  32'h00020000, 32'h12345678, 32'hfff00000, 0, 0, 0},
    '{nps_pkg::OP_CLEAR,  32'h00000000, 32'h00000000, 32'h00000000, 0, 0, 0}
  };

  initial begin
    answer_t typed_ans;
    answer_t none;
    int sent;
    int points;
    none.found = 1'b0;
    none.idx = '0;
    for (int i = 0; i < 3; i++) last_pt[i] = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_ans.found = directed[i].found;
      typed_ans.idx = directed[i].idx;
      send_word(directed[i].op, directed[i].x, directed[i].y, directed[i].z,
                directed[i].typed, typed_ans);
    end

    // Random part: mostly a clear, a run of appends and a few queries; now and then a
    // path filled past capacity, and some loose noise words.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random(op_t'($urandom_range(0, 3)));
        sent++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_random(nps_pkg::OP_CLEAR);
          sent++;
        end
        points = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_POINTS, MAX_POINTS + 3)
                                              : $urandom_range(1, 10);
        repeat (points) send_random(nps_pkg::OP_APPEND);
        sent += points;
        repeat ($urandom_range(1, 6)) begin
          send_random(nps_pkg::OP_QUERY);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // Drain the owed answers, then leave room for a late append to finish.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("nearest_path_edge_search_test passed");
    end else begin
      $display("nearest_path_edge_search_test failed");
    end
    $finish;
  end

endmodule
